FILE: src/min_stk_pkg.sv
package min_stk_pkg;

    localparam int DEPTH_W = 11;
    localparam int DATA_W  = 32;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    typedef enum logic [1:0] {
        ERR_OK    = 2'd0,
        ERR_FULL  = 2'd1,
        ERR_EMPTY = 2'd2
    } err_t;

    typedef enum logic {
        ST_IDLE,
        ST_POP_WAIT
    } state_t;

    typedef struct packed {
        logic push;
        logic pop_short;
        logic pop_read;
        logic pop_load;
        logic report;
        err_t err;
    } dp_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic single;
    } dp_status_t;

endpackage

FILE: src/min_stk_ctrl.sv
module min_stk_ctrl
    import min_stk_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_operation,
    output logic       m_valid,
    input  logic       m_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   m_valid_next;
    logic   accept;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.err      = ERR_OK;
        s_ready      = 1'b0;
        accept       = 1'b0;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            ST_IDLE: begin
                s_ready = !m_valid_reg || m_ready;
                accept  = s_valid && s_ready;
                if (accept) begin
                    if (s_operation == OP_PUSH) begin
                        if (status.full) begin
                            cmd.report = 1'b1;
                            cmd.err    = ERR_FULL;
                        end else begin
                            cmd.push = 1'b1;
                        end
                        m_valid_next = 1'b1;
                    end else begin
                        if (status.empty) begin
                            cmd.report   = 1'b1;
                            cmd.err      = ERR_EMPTY;
                            m_valid_next = 1'b1;
                        end else if (status.single) begin
                            cmd.pop_short = 1'b1;
                            m_valid_next  = 1'b1;
                        end else begin
                            cmd.pop_read = 1'b1;
                            state_next   = ST_POP_WAIT;
                        end
                    end
                end
            end
            ST_POP_WAIT: begin
                cmd.pop_load = 1'b1;
                m_valid_next = 1'b1;
                state_next   = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;

endmodule

FILE: src/min_stk_dp.sv
module min_stk_dp
    import min_stk_pkg::*;
#(
    parameter int STACK_DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  dp_cmd_t                  cmd,
    output dp_status_t               status,
    input  logic signed [DATA_W-1:0] s_value,
    output logic signed [DATA_W-1:0] m_top_value,
    output logic signed [DATA_W-1:0] m_min_value,
    output logic [DEPTH_W-1:0]       m_depth,
    output logic                     m_empty_res,
    output logic [1:0]               m_error
);

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int AW    = $clog2(STACK_DEPTH);

    logic signed [DATA_W-1:0] val_mem [STACK_DEPTH];
    logic signed [DATA_W-1:0] min_mem [STACK_DEPTH];

    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic signed [DATA_W-1:0] top_val_reg;
    logic signed [DATA_W-1:0] top_min_reg;
    logic signed [DATA_W-1:0] rd_val_reg;
    logic signed [DATA_W-1:0] rd_min_reg;
    logic signed [DATA_W-1:0] out_top_reg;
    logic signed [DATA_W-1:0] out_min_reg;
    logic [DEPTH_W-1:0]       out_depth_reg;
    logic                     out_empty_reg;
    err_t                     out_err_reg;

    logic signed [DATA_W-1:0] push_min;
    logic [CNT_W-1:0]         below2;
    logic [AW-1:0]            wr_addr;
    logic [AW-1:0]            rd_addr;
    logic [CNT_W-1:0]         count_inc;

    assign status.full   = (count_reg == CNT_W'(STACK_DEPTH));
    assign status.empty  = (count_reg == '0);
    assign status.single = (count_reg == CNT_W'(1));

    assign push_min  = (status.empty || (s_value < top_min_reg)) ? s_value : top_min_reg;
    assign below2    = count_reg - CNT_W'(2);
    assign rd_addr   = below2[AW-1:0];
    assign wr_addr   = count_reg[AW-1:0];
    assign count_inc = count_reg + CNT_W'(1);

    always_comb begin
        count_next = count_reg;
        if (cmd.push) begin
            count_next = count_inc;
        end else if (cmd.pop_short || cmd.pop_read) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            val_mem[wr_addr] <= s_value;
            min_mem[wr_addr] <= push_min;
        end
        if (cmd.pop_read) begin
            rd_val_reg <= val_mem[rd_addr];
            rd_min_reg <= min_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            top_val_reg   <= s_value;
            top_min_reg   <= push_min;
            out_top_reg   <= s_value;
            out_min_reg   <= push_min;
            out_depth_reg <= DEPTH_W'(count_inc);
            out_empty_reg <= 1'b0;
            out_err_reg   <= ERR_OK;
        end
        if (cmd.pop_short) begin
            out_top_reg   <= '0;
            out_min_reg   <= '0;
            out_depth_reg <= '0;
            out_empty_reg <= 1'b1;
            out_err_reg   <= ERR_OK;
        end
        if (cmd.pop_load) begin
            top_val_reg   <= rd_val_reg;
            top_min_reg   <= rd_min_reg;
            out_top_reg   <= rd_val_reg;
            out_min_reg   <= rd_min_reg;
            out_depth_reg <= DEPTH_W'(count_reg);
            out_empty_reg <= 1'b0;
            out_err_reg   <= ERR_OK;
        end
        if (cmd.report) begin
            out_top_reg   <= status.empty ? '0 : top_val_reg;
            out_min_reg   <= status.empty ? '0 : top_min_reg;
            out_depth_reg <= DEPTH_W'(count_reg);
            out_empty_reg <= status.empty;
            out_err_reg   <= cmd.err;
        end
    end

    assign m_top_value = out_top_reg;
    assign m_min_value = out_min_reg;
    assign m_depth     = out_depth_reg;
    assign m_empty_res = out_empty_reg;
    assign m_error     = out_err_reg;

endmodule

FILE: src/min_tracking_stack.sv
// LIFO stack of signed 32-bit values with a running minimum per entry.
// Input channel (s_valid/s_ready): s_operation 0 pushes s_value, 1 pops.
// Result channel (m_valid/m_ready): one transaction per input transaction,
// carrying the top value, the minimum, the depth, an empty flag and an
// error code (1 push refused on full stack, 2 pop refused on empty stack).
// A push, a refused operation, or a pop that leaves the stack empty
// produces its result in the cycle after acceptance. A pop that leaves
// entries behind passes through ST_POP_WAIT, as the new top comes from
// the registered read port of the entry memory. Pushes sustain one per
// cycle while results are taken; ST_POP_WAIT blocks the input.
// The output register frees s_ready in the same cycle the pending result
// is taken; while the receiver stalls, the input channel stalls with it.
// Reset (aresetn, synchronous, active low) empties the stack and drops
// any pending result; memory contents need no clearing.
module min_tracking_stack
    import min_stk_pkg::*;
#(
    parameter int STACK_DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_operation,
    input  logic signed [DATA_W-1:0] s_value,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [DATA_W-1:0] m_top_value,
    output logic signed [DATA_W-1:0] m_min_value,
    output logic [DEPTH_W-1:0]       m_depth,
    output logic                     m_empty_res,
    output logic [1:0]               m_error
);

    dp_cmd_t    cmd;
    dp_status_t status;

    min_stk_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .status      (status),
        .cmd         (cmd)
    );

    min_stk_dp #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .s_value     (s_value),
        .m_top_value (m_top_value),
        .m_min_value (m_min_value),
        .m_depth     (m_depth),
        .m_empty_res (m_empty_res),
        .m_error     (m_error)
    );

endmodule
